>>> design/mde_pkg.sv
// ----------------------------------------------------------------------------
// mde_pkg
// shared types, constants and tables of the multiband downward expander
// ----------------------------------------------------------------------------
package mde_pkg;

    localparam int NUM_BANDS_DEF   = 4;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int NUM_SET_REGS = 4;
    localparam logic [CFG_IDX_W-1:0] REG_BANDS_IN_USE = 3'd0;
    // band settings registers follow in band order
    localparam logic [CFG_IDX_W-1:0] REG_BAND_SET_0   = 3'd1;

    localparam int MB_W   = 32;
    localparam int LVL_W  = 24;
    localparam int GAIN_W = 26;

    localparam int LOG_ZERO_Q16  = -1306235;
    localparam int DB_TO_LOG2    = 10885;
    localparam int GAIN_LOG_MAX  = 8 * 65536 - 1;
    localparam int GAIN_LOG_MIN  = -40 * 65536;
    localparam int UNITY_Q16     = 65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_ABS,
        S_ENV_MUL,
        S_ENV_UPD,
        S_NORM,
        S_SQ,
        S_SQ_CHK,
        S_THR,
        S_GLOG,
        S_EXP_MUL,
        S_EXP_SH,
        S_APPLY,
        S_ACC,
        S_DONE
    } t_state;

    // 2^(k/16) in q16
    function automatic logic [17:0] exp2_tab(input logic [4:0] k);
        logic [17:0] v;
        case (k)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

>>> design/mde_mul.sv
// ----------------------------------------------------------------------------
// mde_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module mde_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic                     i_clk,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_p
);
    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> design/multiband_downward_expander.sv
// ----------------------------------------------------------------------------
// multiband_downward_expander
// per band scale, envelope follower, log2 level, expansion gain, summed output
// ----------------------------------------------------------------------------
// operation: with no band in use the sample passes straight through; else
//   per band scale, envelope update, then, unless the envelope is zero,
//   normalize and the 16 squaring steps of the log2 level, then gain and sum
// sharing: the single shared multiplier serves every multiplying step, and
//   the block takes no new sample while busy or while a result is pending
// reset: synchronous active low, clears settings, envelopes and control
module multiband_downward_expander #(
    parameter int NUM_BANDS   = mde_pkg::NUM_BANDS_DEF,
    parameter int SAMPLE_BITS = mde_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   i_s_tdata,  // in_sample
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   o_m_tdata,  // out_sample
    output logic                               o_m_tuser,  // clipped
    input  logic                               i_cfg_we,
    input  logic [mde_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mde_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mde_pkg::*;

    localparam int W   = SAMPLE_BITS;
    localparam int DW  = ((W+7)/8)*8;
    localparam int FW  = W + 2;
    localparam int MA  = (FW > 32) ? FW : 32;
    localparam int PW  = MA + MB_W;
    localparam int AW  = W + 13;
    localparam int BIW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int BCW = $clog2(NUM_BANDS + 1);
    localparam int LZW = $clog2(W + 1);

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_cfg [NUM_BANDS];
    logic [W-1:0]          r_env [NUM_BANDS];
    logic [2:0]            r_bands;

    logic [BIW-1:0]          r_band;
    logic [BCW-1:0]          r_n;
    logic [3:0]              r_i;
    logic signed [W-1:0]     r_s;
    logic signed [FW-1:0]    r_f;
    logic [W-1:0]            r_a;
    logic [W-1:0]            r_m;
    logic [30:0]             r_q;
    logic [LZW-1:0]          r_lz;
    logic [15:0]             r_frac;
    logic signed [LVL_W-1:0] r_lvl;
    logic signed [LVL_W-1:0] r_g;
    logic [GAIN_W-1:0]       r_gain;
    logic signed [AW-1:0]    r_acc;
    logic [W-1:0]            r_out;
    logic                    r_clip;
    logic                    r_ovalid;

    logic signed [MA-1:0]   mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PW-1:0]   prod;

    mde_mul #(.A_W(MA), .B_W(MB_W)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    logic                    in_acc;
    logic [BCW-1:0]          n_eff;
    logic [CFG_DATA_W-1:0]   cfg;
    logic [W-1:0]            env_cur;
    logic [15:0]             coeff;
    logic signed [W:0]       env_diff;
    logic [W-1:0]            env_new;
    logic signed [FW-1:0]    f_full;
    logic [FW-1:0]           f_abs;
    logic [W-1:0]            a_sat;
    logic [W+30:0]           m_wide;
    logic [31:0]             sq;
    logic [15:0]             frac_new;
    logic signed [LVL_W-1:0] thr_x;
    logic signed [LVL_W-1:0] t2;
    logic signed [LVL_W-1:0] lvl_gap;
    logic signed [31:0]      g_raw;
    logic [3:0]              e_idx;
    logic [17:0]             e_lo;
    logic [17:0]             e_hi;
    logic [17:0]             mant;
    logic signed [7:0]       e_ip;
    logic [7:0]              e_nip;
    logic                    last_band;
    logic signed [AW-1:0]    acc_hi;
    logic signed [AW-1:0]    acc_lo;

    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE) && !r_ovalid;
    assign n_eff      = ({1'b0, r_bands} > 4'(NUM_BANDS)) ? BCW'(NUM_BANDS) : BCW'(r_bands);
    assign cfg        = r_cfg[r_band];
    assign env_cur    = r_env[r_band];
    assign coeff      = (r_a > env_cur) ? cfg[31:16] : cfg[47:32];
    assign env_diff   = $signed({1'b0, r_a}) - $signed({1'b0, env_cur});
    assign env_new    = env_cur + W'(prod >>> 16);
    assign f_full     = FW'(prod >>> 15);
    assign f_abs      = f_full[FW-1] ? FW'(-f_full) : FW'(f_full);
    assign a_sat      = (f_abs[FW-1:W] != '0) ? '1 : f_abs[W-1:0];
    assign m_wide     = {r_m, 31'd0};
    assign sq         = prod[61:30];
    assign frac_new   = sq[31] ? (r_frac | (16'h8000 >> r_i)) : r_frac;
    assign thr_x      = LVL_W'($signed(cfg[55:48]));
    assign t2         = thr_x * LVL_W'(DB_TO_LOG2);
    assign lvl_gap    = t2 - r_lvl;
    assign g_raw      = 32'(t2) - $signed({2'b00, prod[33:4]});
    assign e_idx      = r_g[15:12];
    assign e_lo       = exp2_tab({1'b0, e_idx});
    assign e_hi       = exp2_tab(5'({1'b0, e_idx}) + 5'd1);
    assign mant       = e_lo + prod[29:12];
    assign e_ip       = r_g[LVL_W-1:16];
    assign e_nip      = 8'(-e_ip);
    assign last_band  = ({1'b0, r_band} == (BIW+1)'(r_n - 1'b1));
    assign acc_hi     = AW'((64'sd1 <<< (W-1)) - 1);
    assign acc_lo     = AW'(-(64'sd1 <<< (W-1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && n_eff != '0) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                mul_a   = MA'(r_s);
                mul_b   = $signed({16'd0, cfg[15:0]});
                n_state = S_ABS;
            end
            S_ABS:     n_state = S_ENV_MUL;
            S_ENV_MUL: begin
                mul_a   = MA'(env_diff);
                mul_b   = $signed({16'd0, coeff});
                n_state = S_ENV_UPD;
            end
            S_ENV_UPD: n_state = (env_new == '0) ? S_THR : S_NORM;
            S_NORM:    n_state = r_m[W-1] ? S_SQ : S_NORM;
            S_SQ: begin
                mul_a   = $signed(MA'(r_q));
                mul_b   = $signed({1'b0, r_q});
                n_state = S_SQ_CHK;
            end
            S_SQ_CHK:  n_state = (r_i == 4'd15) ? S_THR : S_SQ;
            S_THR: begin
                mul_a   = MA'(lvl_gap);
                mul_b   = $signed({24'd0, cfg[63:56]});
                n_state = (r_lvl < t2) ? S_GLOG : S_APPLY;
            end
            S_GLOG:    n_state = S_EXP_MUL;
            S_EXP_MUL: begin
                mul_a   = $signed(MA'(e_hi - e_lo));
                mul_b   = $signed({20'd0, r_g[11:0]});
                n_state = S_EXP_SH;
            end
            S_EXP_SH:  n_state = S_APPLY;
            S_APPLY: begin
                mul_a   = MA'(r_f);
                mul_b   = $signed(MB_W'(r_gain));
                n_state = S_ACC;
            end
            S_ACC:     n_state = last_band ? S_DONE : S_SCALE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bands  <= '0;
            r_ovalid <= 1'b0;
            r_band   <= '0;
            r_n      <= '0;
            r_i      <= '0;
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_cfg[b] <= '0;
                r_env[b] <= '0;
            end
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BANDS_IN_USE) begin
                    r_bands <= i_cfg_data[2:0];
                end
                for (int b = 0; b < NUM_BANDS; b++) begin
                    if (b < NUM_SET_REGS && i_cfg_idx == REG_BAND_SET_0 + CFG_IDX_W'(b)) begin
                        r_cfg[b] <= i_cfg_data;
                        r_env[b] <= '0;
                    end
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_s    <= i_s_tdata[W-1:0];
                        r_n    <= n_eff;
                        r_band <= '0;
                        r_acc  <= '0;
                        if (n_eff == '0) begin
                            // pass through
                            r_out    <= i_s_tdata[W-1:0];
                            r_clip   <= 1'b0;
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_ABS: begin
                    r_f <= f_full;
                    r_a <= a_sat;
                end
                S_ENV_UPD: begin
                    r_env[r_band] <= env_new;
                    r_m           <= env_new;
                    r_lz          <= '0;
                    r_lvl         <= LVL_W'(LOG_ZERO_Q16);
                end
                S_NORM: begin
                    if (r_m[W-1]) begin
                        r_q    <= m_wide[W+30 -: 31];
                        r_i    <= '0;
                        r_frac <= '0;
                    end else if (r_m[W-1 -: 4] == 4'd0) begin
                        r_m  <= r_m << 4;
                        r_lz <= r_lz + LZW'(4);
                    end else begin
                        r_m  <= r_m << 1;
                        r_lz <= r_lz + LZW'(1);
                    end
                end
                S_SQ_CHK: begin
                    r_q    <= sq[31] ? sq[31:1] : sq[30:0];
                    r_frac <= frac_new;
                    r_i    <= r_i + 4'd1;
                    r_lvl  <= LVL_W'(frac_new) - (LVL_W'(r_lz) << 16);
                end
                S_THR: begin
                    r_gain <= GAIN_W'(UNITY_Q16);
                end
                S_GLOG: begin
                    if (g_raw > 32'(GAIN_LOG_MAX)) begin
                        r_g <= LVL_W'(GAIN_LOG_MAX);
                    end else if (g_raw < 32'(GAIN_LOG_MIN)) begin
                        r_g <= LVL_W'(GAIN_LOG_MIN);
                    end else begin
                        r_g <= LVL_W'(g_raw);
                    end
                end
                S_EXP_SH: begin
                    if (!e_ip[7]) begin
                        r_gain <= GAIN_W'(mant) << e_ip[2:0];
                    end else begin
                        r_gain <= GAIN_W'(mant >> e_nip);
                    end
                end
                S_ACC: begin
                    r_acc <= r_acc + AW'(prod >>> 16);
                    if (!last_band) begin
                        r_band <= r_band + 1'b1;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    if (r_acc > acc_hi) begin
                        r_out  <= acc_hi[W-1:0];
                        r_clip <= 1'b1;
                    end else if (r_acc < acc_lo) begin
                        r_out  <= acc_lo[W-1:0];
                        r_clip <= 1'b1;
                    end else begin
                        r_out  <= r_acc[W-1:0];
                        r_clip <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = DW'(r_out);
    assign o_m_tuser  = r_clip;

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_tready)
        else $error("ready held right after a request");

    a_band_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ({1'b0, r_band} < (BIW+1)'(r_n)))
        else $error("band index beyond bands in use");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_ovalid)
        else $error("result overwrites a pending one");

endmodule

>>> dv/tb_multiband_downward_expander.sv
// ----------------------------------------------------------------------------
// tb_multiband_downward_expander
// random and directed samples through the expander under several band
// settings; each result is checked against a bit exact predictor of the
// envelope, level, gain and saturating sum
// ----------------------------------------------------------------------------
module tb_multiband_downward_expander;
    import mde_pkg::*;

    localparam int NB = 4;
    localparam int SB = 24;
    localparam logic [63:0] SMASK = (64'd1 << SB) - 1;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [SB-1:0] sample;
        logic          clip;
    } t_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [SB-1:0]         i_s_tdata;   // in_sample
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [SB-1:0]         o_m_tdata;   // out_sample
    logic                  o_m_tuser;   // clipped
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    multiband_downward_expander i_dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // expander model state
    logic [63:0] band_env [NB];
    logic [63:0] band_set [NB];
    logic [2:0]  active_bands;

    logic [SB-1:0] sample_q[$];
    t_result       expected_q[$];
    int            errors;
    int            send_idle_pct;
    int            recv_stall_pct;
    longint        cycle_cnt = 0;
    logic          o_s_tready_q;

    function automatic longint asr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint level_log2(logic [63:0] e);
        int p;
        logic [63:0] m;
        longint frac;
        p = 0;
        frac = 0;
        while (p < 63 && (e >> (p + 1)) != 0) p++;
        m = (p <= 30) ? (e << (30 - p)) : (e >> (p - 30));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | (longint'(1) << (15 - i));
            end
        end
        return (longint'(p) - (SB - 1)) * 65536 + frac;
    endfunction

    function automatic logic [63:0] gain_exp2(longint g);
        longint ip, fp;
        int idx;
        logic [63:0] r, mant, t0, t1;
        ip = g >>> 16;
        fp = g - ip * 65536;
        idx = int'((fp >> 12) & 15);
        r = fp & 64'hFFF;
        t0 = exp2_tab(5'(idx));
        t1 = exp2_tab(5'(idx + 1));
        mant = t0 + (((t1 - t0) * r) >> 12);
        if (ip >= 0) return mant << ip;
        if (-ip >= 40) return 0;
        return mant >> (-ip);
    endfunction

    function automatic t_result expand_sample(logic [SB-1:0] x);
        t_result res;
        int n;
        longint s, acc, f, a, env, lvl, t2, g, att, rel, thr;
        logic [63:0] cfg, ratio, gain;
        n = (active_bands > NB) ? NB : active_bands;
        s = longint'($signed(x));
        acc = 0;
        if (n == 0) begin
            res.sample = x;
            res.clip = 1'b0;
            return res;
        end
        for (int b = 0; b < n; b++) begin
            cfg = band_set[b];
            att = longint'(cfg[31:16]);
            rel = longint'(cfg[47:32]);
            thr = longint'($signed(cfg[55:48]));
            ratio = cfg[63:56];
            f = asr(s * longint'(cfg[15:0]), 15);
            a = (f < 0) ? -f : f;
            if (a > longint'(SMASK)) a = longint'(SMASK);
            env = longint'(band_env[b]);
            env = env + asr((a - env) * ((a > env) ? att : rel), 16);
            band_env[b] = env & SMASK;
            lvl = (band_env[b] != 0) ? level_log2(band_env[b]) : LOG_ZERO_Q16;
            t2 = thr * DB_TO_LOG2;
            if (lvl < t2) begin
                g = t2 - longint'((64'(t2 - lvl) * ratio) >> 4);
                if (g > GAIN_LOG_MAX) g = GAIN_LOG_MAX;
                if (g < GAIN_LOG_MIN) g = GAIN_LOG_MIN;
                gain = gain_exp2(g);
            end else begin
                gain = UNITY_Q16;
            end
            acc = acc + asr(f * longint'(gain), 16);
        end
        if (acc > 8388607) begin
            res.sample = 24'h7FFFFF;
            res.clip = 1'b1;
        end else if (acc < -8388608) begin
            res.sample = 24'h800000;
            res.clip = 1'b1;
        end else begin
            res.sample = acc[SB-1:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // driver: predicts at acceptance so state follows the request order
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready_q) begin
                expected_q.push_back(expand_sample(i_s_tdata));
                void'(sample_q.pop_front());
            end
            if (sample_q.size() > 0 && ($urandom_range(99) >= send_idle_pct ||
                (i_s_tvalid && !o_s_tready_q))) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= sample_q[0];
            end else if (!(i_s_tvalid && !o_s_tready_q)) begin
                i_s_tvalid <= 1'b0;
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // handshake seen at the rising edge, used by the driver on the falling edge
    always @(posedge i_clk) begin
        o_s_tready_q <= o_s_tready && i_s_tvalid;
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata, 0);
            end else begin
                want = expected_q.pop_front();
                if (o_m_tdata !== want.sample)
                    report_mismatch("out_sample", o_m_tdata, want.sample);
                if (o_m_tuser !== want.clip)
                    report_mismatch("clipped", o_m_tuser, want.clip);
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (sample_q.size() > 0 || i_s_tvalid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_BANDS_IN_USE) begin
            active_bands = val[2:0];
        end else if (idx >= REG_BAND_SET_0 && idx < REG_BAND_SET_0 + NB) begin
            band_set[idx - REG_BAND_SET_0] = val;
            band_env[idx - REG_BAND_SET_0] = 0;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] band_word(int kind);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case (kind)
            0: w[55:48] = 8'($urandom_range(0, 40)) - 8'd60;   // typical
            1: w = 64'hFFFF_FFFF_FFFF_FFFF;
            2: w = 64'h0;
            default: ;
        endcase
        if (kind == 0) begin
            w[63:56] = 8'($urandom_range(16, 64));
            w[15:0]  = 16'($urandom_range(8192, 40000));
        end
        return w;
    endfunction

    task automatic run_phase(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0: sample_q.push_back(24'($urandom));
                1: sample_q.push_back(24'($signed(12'($urandom))));
                2: sample_q.push_back($urandom_range(1) ? 24'h7FFFFF : 24'h800000);
                default: sample_q.push_back(24'($signed(18'($urandom))));
            endcase
        end
        wait_drained();
    endtask

    initial begin
        logic [SB-1:0] edges [6];
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        active_bands = 0;
        for (int b = 0; b < NB; b++) begin
            band_env[b] = 0;
            band_set[b] = 0;
        end
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: pass through, then extremes with every band live
        edges = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF, 24'h400000};
        foreach (edges[j]) sample_q.push_back(edges[j]);
        wait_drained();
        for (int b = 0; b < NB; b++)
            write_reg(REG_BAND_SET_0 + CFG_IDX_W'(b), 64'h20FF_FFFF_FFFF_8000);
        write_reg(REG_BANDS_IN_USE, 64'd4);
        foreach (edges[j]) sample_q.push_back(edges[j]);
        wait_drained();
        // full scale settings clip the sum; unmapped index and too many bands
        for (int b = 0; b < NB; b++)
            write_reg(REG_BAND_SET_0 + CFG_IDX_W'(b), band_word(1));
        write_reg('1, 64'hDEAD_BEEF_0123_4567);
        write_reg(REG_BANDS_IN_USE, 64'd7);
        foreach (edges[j]) sample_q.push_back(edges[j]);
        wait_drained();
        write_reg(REG_BANDS_IN_USE, 64'd1);
        write_reg(REG_BAND_SET_0, band_word(2));
        foreach (edges[j]) sample_q.push_back(edges[j]);
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            for (int b = 0; b < NB; b++)
                write_reg(REG_BAND_SET_0 + CFG_IDX_W'(b),
                          band_word((ph == 7) ? 1 : $urandom_range(0, 3)));
            write_reg(REG_BANDS_IN_USE, 64'(ph == 0 ? 0 : $urandom_range(1, 7)));
            case (ph % 4)
                0: run_phase(180, 0, 0);
                1: run_phase(180, 71, 0);
                2: run_phase(180, 0, 71);
                default: run_phase(180, 22, 22);
            endcase
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/mde_pkg.sv
design/mde_mul.sv
design/multiband_downward_expander.sv
dv/tb_multiband_downward_expander.sv
